/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the point transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising edge outside reset.
`define PTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define PTP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/ptp_pkg.sv */
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants and types for the 4x4 point transform with divide.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int FIELD_W   = 32;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = 64;
    localparam int REM_W     = MAG_W + COORD_WIDTH + FRAC_BITS;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int DATA_W    = 3 * FIELD_W;
    localparam int USER_W    = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

    localparam logic [REG_W-1:0] FX_ONE = REG_W'(1) << FRAC_BITS;

    // identity matrix at reset
    function automatic logic [REG_W-1:0] reg_reset(input logic [REG_IDX_W-1:0] idx);
        logic [REG_W-1:0] v;
        v = '0;
        unique case (idx)
            REG_ROW0_C01: v = FX_ONE;
            REG_ROW1_C01: v = FX_ONE << COEF_W;
            REG_ROW2_C23: v = FX_ONE;
            REG_ROW3_C23: v = FX_ONE << COEF_W;
            default:      v = '0;
        endcase
        return v;
    endfunction

    // word handed from front to back
    typedef struct packed {
        logic [2:0][MAG_W-1:0]   nmag;
        logic [2:0]              nneg;
        logic [MAG_W-1:0]        dmag;
        logic                    dneg;
        logic                    degen;
        logic [2:0][FIELD_W-1:0] pt;
    } t_sum_word;

    // queue status for the top level
    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] level;
    } t_fifo_stat;

endpackage

/* src/point_transform_perspective_unit.sv */
// ----------------------------------------------------------------------------
// point_transform_perspective_unit
// 4x4 homogeneous point transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)       tuser (low bit up)
//  s_axis   in   x[31:0] y z              -
//  m_axis   out  x[31:0] y z              degenerate, saturated
//  cfg      in   i_cfg_addr 0..7, 64-bit  writes to 8+ ignored
//
//  One point per cycle while m_axis accepts; each point passes the front stages
//  a to d, the queue and then the divide pipe (one stage per quotient bit plus entry
//  and output registers). Reset is synchronous and loads the identity matrix.
//  A stalled m_axis freezes the divide pipe; the 4-word queue keeps the
//  front running until it fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_transform_perspective_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [ptp_pkg::REG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ptp_pkg::DATA_W-1:0]         s_axis_tdata,  // in_x, in_y, in_z
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ptp_pkg::DATA_W-1:0]         m_axis_tdata,  // out_x, out_y, out_z
    output logic [ptp_pkg::USER_W-1:0]         m_axis_tuser   // degenerate, saturated
);
    ptp_pkg::t_sum_word   w_push_word, w_head;
    ptp_pkg::t_fifo_stat  w_stat;
    logic                 w_push, w_pop;

    // front: products and row sums
    ptp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .o_push     (w_push),
        .o_word     (w_push_word),
        .i_full     (w_stat.full)
    );

    ptp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .i_pop   (w_pop),
        .o_word  (w_head),
        .o_stat  (w_stat)
    );

    // back: divide, clamp, output register
    ptp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_stat.empty),
        .i_word  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

    `PTP_NEVER(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "degenerate and saturated together")
    `PTP_NEVER(a_fifo_bound, i_clk, i_rst_n, w_stat.level > ptp_pkg::FIFO_CNT_W'(ptp_pkg::FIFO_DEPTH), "queue over depth")
    `PTP_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_stat.full, "push into full queue")
    `PTP_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_stat.empty, "pop from empty queue")

endmodule

/* src/ptp_front.sv */
// ----------------------------------------------------------------------------
// ptp_front
// Matrix registers, coordinate products and row sums, sign/magnitude split.
// ----------------------------------------------------------------------------
module ptp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ptp_pkg::REG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ptp_pkg::DATA_W-1:0]          i_data,
    output logic                                o_push,
    output ptp_pkg::t_sum_word                  o_word,
    input  logic                                i_full
);
    localparam int CW = ptp_pkg::COORD_WIDTH;
    localparam int FB = ptp_pkg::FRAC_BITS;
    localparam int FW = ptp_pkg::FIELD_W;
    localparam int CF = ptp_pkg::COEF_W;

    logic [ptp_pkg::REG_W-1:0] r_regs [ptp_pkg::NUM_REGS];

    logic                               r_a_v, r_b_v, r_c_v, r_d_v;
    logic signed [FW-1:0]               r_a_p [3];
    logic signed [ptp_pkg::PROD_W-1:0]  r_b_prod [4][3];
    logic [2:0][FW-1:0]                 r_b_pt, r_c_pt;
    logic signed [ptp_pkg::SUM_W-1:0]   r_c_sum [4];
    ptp_pkg::t_sum_word                 r_d_word;
    logic                               w_en;

    assign w_en    = !(r_d_v && i_full);
    assign o_ready = w_en;
    assign o_push  = r_d_v && !i_full;
    assign o_word  = r_d_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ptp_pkg::NUM_REGS; i++) begin
                r_regs[i] <= ptp_pkg::reg_reset(ptp_pkg::REG_IDX_W'(i));
            end
        end else if (i_cfg_we && i_cfg_addr < ptp_pkg::CFG_IDX_W'(ptp_pkg::NUM_REGS)) begin
            r_regs[i_cfg_addr[ptp_pkg::REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // coordinates: low CW bits, sign at bit CW-1
            for (int k = 0; k < 3; k++) begin
                r_a_p[k] <= $signed(i_data[k*FW +: FW] << (FW - CW)) >>> (FW - CW);
            end
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_b_prod[r][c] <= ptp_pkg::PROD_W'(
                        $signed(r_regs[r*2 + c/2][(c%2)*CF +: CF]) * r_a_p[c]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_b_pt[k] <= r_a_p[k];
            end
            for (int r = 0; r < 4; r++) begin
                r_c_sum[r] <= ptp_pkg::SUM_W'(r_b_prod[r][0])
                            + ptp_pkg::SUM_W'(r_b_prod[r][1])
                            + ptp_pkg::SUM_W'(r_b_prod[r][2])
                            + (ptp_pkg::SUM_W'($signed(r_regs[r*2+1][CF +: CF])) <<< FB);
            end
            r_c_pt <= r_b_pt;
            for (int r = 0; r < 3; r++) begin
                r_d_word.nneg[r] <= r_c_sum[r][ptp_pkg::SUM_W-1];
                r_d_word.nmag[r] <= r_c_sum[r][ptp_pkg::SUM_W-1]
                                  ? ptp_pkg::MAG_W'(-r_c_sum[r])
                                  : ptp_pkg::MAG_W'(r_c_sum[r]);
            end
            r_d_word.dneg  <= r_c_sum[3][ptp_pkg::SUM_W-1];
            r_d_word.dmag  <= r_c_sum[3][ptp_pkg::SUM_W-1]
                            ? ptp_pkg::MAG_W'(-r_c_sum[3]) : ptp_pkg::MAG_W'(r_c_sum[3]);
            r_d_word.degen <= (r_c_sum[3] == '0);
            r_d_word.pt    <= r_c_pt;
        end
    end

endmodule

/* src/ptp_fifo.sv */
// ----------------------------------------------------------------------------
// ptp_fifo
// Short queue between the sum front and the divide back.
// ----------------------------------------------------------------------------
module ptp_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ptp_pkg::t_sum_word   i_word,
    input  logic                 i_pop,
    output ptp_pkg::t_sum_word   o_word,
    output ptp_pkg::t_fifo_stat  o_stat
);
    ptp_pkg::t_sum_word                r_mem [ptp_pkg::FIFO_DEPTH];
    logic [ptp_pkg::FIFO_PTR_W-1:0]    r_wp, r_rp;
    logic [ptp_pkg::FIFO_CNT_W-1:0]    r_cnt;

    assign o_word       = r_mem[r_rp];
    assign o_stat.level = r_cnt;
    assign o_stat.full  = (r_cnt == ptp_pkg::FIFO_CNT_W'(ptp_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + ptp_pkg::FIFO_CNT_W'(i_push) - ptp_pkg::FIFO_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_word;
    end

endmodule

/* src/ptp_back.sv */
// ----------------------------------------------------------------------------
// ptp_back
// Pipelined restoring divide, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module ptp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  ptp_pkg::t_sum_word            i_word,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptp_pkg::DATA_W-1:0]    o_data,
    output logic [ptp_pkg::USER_W-1:0]    o_user
);
    localparam int QW = ptp_pkg::COORD_WIDTH;
    localparam int FB = ptp_pkg::FRAC_BITS;
    localparam int RW = ptp_pkg::REM_W;
    localparam int FW = ptp_pkg::FIELD_W;

    logic                 r_v    [QW+1];
    logic [RW-1:0]        r_rem  [QW+1][3];
    logic [QW-1:0]        r_q    [QW+1][3];
    logic [2:0]           r_ovf  [QW+1];
    logic [2:0]           r_neg  [QW+1];
    logic [ptp_pkg::MAG_W-1:0] r_d [QW+1];
    logic                 r_dg   [QW+1];
    logic [2:0][FW-1:0]   r_pt   [QW+1];
    logic                 r_ov;
    logic                 w_en;

    logic [RW-1:0]        w_num  [3];
    logic [RW-1:0]        w_dtop;

    assign w_en    = !r_ov || i_ready;
    assign o_pop   = i_avail && w_en;
    assign o_valid = r_ov;

    always_comb begin
        w_dtop = RW'(i_word.dmag) << QW;
        for (int k = 0; k < 3; k++) begin
            w_num[k] = RW'(i_word.nmag[k]) << FB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_avail;
            for (int s = 0; s < QW; s++) r_v[s+1] <= r_v[s];
            r_ov <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // entry: quotient must fit QW bits, else it saturates
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k]  <= w_num[k];
                r_q[0][k]    <= '0;
                r_ovf[0][k]  <= (w_num[k] >= w_dtop);
                r_neg[0][k]  <= i_word.nneg[k] ^ i_word.dneg;
            end
            r_d[0]  <= i_word.dmag;
            r_dg[0] <= i_word.degen;
            r_pt[0] <= i_word.pt;
            for (int s = 0; s < QW; s++) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[s][k] >= (RW'(r_d[s]) << (QW-1-s))) begin
                        r_rem[s+1][k] <= r_rem[s][k] - (RW'(r_d[s]) << (QW-1-s));
                        r_q[s+1][k]   <= r_q[s][k] | (QW'(1) << (QW-1-s));
                    end else begin
                        r_rem[s+1][k] <= r_rem[s][k];
                        r_q[s+1][k]   <= r_q[s][k];
                    end
                end
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
                r_d[s+1]   <= r_d[s];
                r_dg[s+1]  <= r_dg[s];
                r_pt[s+1]  <= r_pt[s];
            end
        end
    end

    // final clamp and sign
    logic [FW-1:0]  w_out [3];
    logic [2:0]     w_sat;
    logic [QW-1:0]  w_bound, w_val;

    always_comb begin
        w_bound = '0;
        w_val   = '0;
        for (int k = 0; k < 3; k++) begin
            w_bound  = (QW'(1) << (QW-1)) - QW'(!r_neg[QW][k]);
            w_sat[k] = r_ovf[QW][k] || (r_q[QW][k] > w_bound);
            w_val    = w_sat[k] ? w_bound : r_q[QW][k];
            w_val    = r_neg[QW][k] ? (QW'(0) - w_val) : w_val;
            w_out[k] = FW'($signed(w_val));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                o_data[k*FW +: FW] <= r_dg[QW] ? r_pt[QW][k] : w_out[k];
            end
            o_user[0] <= r_dg[QW];
            o_user[1] <= !r_dg[QW] && (w_sat != '0);
        end
    end

endmodule
